>>> design/sexpr_stream_lexer_core_defines.svh
// ----------------------------------------------------------------------------
// sexpr_stream_lexer_core_defines.svh
// Assertion macros shared by the lexer core files.
// ----------------------------------------------------------------------------
`ifndef SEXPR_STREAM_LEXER_CORE_DEFINES_SVH
`define SEXPR_STREAM_LEXER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SXL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SXL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sxl_pkg.sv
// ----------------------------------------------------------------------------
// sxl_pkg
// Types, character codes and classifier functions of the S-expression lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sxl_pkg;

   localparam int MAX_DEPTH_DEFAULT = 255;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DASH   = 8'h2D;

   typedef enum logic [3:0] {
      MODE_GAP        = 4'd0,
      MODE_COMMENT    = 4'd1,
      MODE_NAME_START = 4'd2,
      MODE_NAME       = 4'd3,
      MODE_TOKEN      = 4'd4,
      MODE_STR        = 4'd5,
      MODE_ESC        = 4'd6
   } mode_type;

   typedef enum logic [3:0] {
      EV_SKIP      = 4'd0,
      EV_OPEN      = 4'd1,
      EV_NAME      = 4'd2,
      EV_TOKEN     = 4'd3,
      EV_STR_OPEN  = 4'd4,
      EV_STR_CHAR  = 4'd5,
      EV_STR_CLOSE = 4'd6,
      EV_BREAK     = 4'd7,
      EV_CLOSE     = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_NODE  = 3'd1,
      ST_NO_CLOSE = 3'd2,
      ST_OPEN_STR = 3'd3,
      ST_BAD_ESC  = 3'd4,
      ST_BAD_CHAR = 3'd5,
      ST_EXTRA    = 3'd6,
      ST_DEEP     = 3'd7
   } status_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] depth;
      status_type err;
      logic       root;
   } state_type;

   typedef struct packed {
      event_type  event_kind;
      logic [7:0] char_value;
      logic       first_char;
      logic [7:0] nest_depth;
      logic       doc_done;
      status_type doc_status;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, 8'h0C, 8'h0D, 8'h09, 8'h0B};
   endfunction

   function automatic logic is_tok(input logic [7:0] b);
      return b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                       CH_BSLASH, CH_DOT, CH_COLON, CH_USCORE, CH_DASH};
   endfunction

   // Bit 8 flags a legal escape; bits 7:0 hold the resolved character.
   function automatic logic [8:0] esc_value(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h27:   r = {1'b1, 8'h27};
         8'h22:   r = {1'b1, 8'h22};
         8'h3F:   r = {1'b1, 8'h3F};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h61:   r = {1'b1, 8'h07};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         8'h76:   r = {1'b1, 8'h0B};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> design/sxl_if.sv
// ----------------------------------------------------------------------------
// sxl_if
// Valid/ready channel interfaces for document bytes and lexer results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sxl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       is_last;

   modport source (output valid, output byte_in, output is_last, input ready);
   modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface sxl_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_kind;
   logic [7:0] char_value;
   logic       first_char;
   logic [7:0] nest_depth;
   logic       doc_done;
   logic [2:0] doc_status;

   modport source (output valid, output event_kind, output char_value,
                   output first_char, output nest_depth, output doc_done,
                   output doc_status, input ready);
   modport sink   (input valid, input event_kind, input char_value,
                   input first_char, input nest_depth, input doc_done,
                   input doc_status, output ready);
endinterface

>>> design/sxl_step.sv
// ----------------------------------------------------------------------------
// sxl_step
// Next lexer state and result event for one document byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sxl_step #(
   parameter int MAX_DEPTH = sxl_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic [7:0]         byte_in,
   input  logic               is_last,
   input  sxl_pkg::state_type cur_state,
   output sxl_pkg::state_type nxt_state,
   output sxl_pkg::result_type result
);
   import sxl_pkg::*;

   localparam int DEPTH_LIMIT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
   localparam logic [7:0] LIMIT = 8'(DEPTH_LIMIT);

   state_type  st;
   event_type  ev;
   logic [7:0] ch;
   logic       first;
   logic       do_gap;
   logic [8:0] esc;
   status_type status;

   always_comb begin
      st     = cur_state;
      ev     = EV_SKIP;
      ch     = 8'd0;
      first  = 1'b0;
      do_gap = 1'b0;
      esc    = esc_value(byte_in);

      if (cur_state.err == ST_OK) begin
         case (cur_state.mode)
            MODE_COMMENT: begin
               if (byte_in == CH_NL) begin
                  st.mode = MODE_GAP;
                  if (cur_state.depth != 8'd0) ev = EV_BREAK;
               end
            end
            MODE_NAME_START: begin
               if (is_tok(byte_in)) begin
                  st.mode = MODE_NAME;
                  ev      = EV_NAME;
                  ch      = byte_in;
                  first   = 1'b1;
               end else begin
                  st.err = ST_BAD_CHAR;
               end
            end
            MODE_NAME, MODE_TOKEN: begin
               if (is_tok(byte_in)) begin
                  ev = (cur_state.mode == MODE_NAME) ? EV_NAME : EV_TOKEN;
                  ch = byte_in;
               end else begin
                  do_gap = 1'b1;
               end
            end
            MODE_STR: begin
               if (byte_in == CH_QUOTE) begin
                  st.mode = MODE_GAP;
                  ev      = EV_STR_CLOSE;
               end else if (byte_in == CH_BSLASH) begin
                  st.mode = MODE_ESC;
               end else begin
                  ev = EV_STR_CHAR;
                  ch = byte_in;
               end
            end
            MODE_ESC: begin
               if (esc[8]) begin
                  st.mode = MODE_STR;
                  ev      = EV_STR_CHAR;
                  ch      = esc[7:0];
               end else begin
                  st.err = ST_BAD_ESC;
               end
            end
            default: do_gap = 1'b1;
         endcase
      end

      // A byte between items, or the byte that ends a name or token.
      if (do_gap) begin
         st.mode = MODE_GAP;
         if (is_space(byte_in)) begin
            st.mode = MODE_GAP;
         end else if (byte_in == CH_SEMI) begin
            st.mode = MODE_COMMENT;
         end else if (cur_state.depth == 8'd0 && byte_in == CH_NL) begin
            st.mode = MODE_GAP;
         end else if (cur_state.depth == 8'd0 && cur_state.root) begin
            st.err = ST_EXTRA;
         end else if (cur_state.depth != 8'd0 && byte_in == CH_NL) begin
            ev = EV_BREAK;
         end else if (cur_state.depth != 8'd0 && byte_in == CH_RPAREN) begin
            st.depth = cur_state.depth - 8'd1;
            ev       = EV_CLOSE;
         end else if (byte_in == CH_LPAREN) begin
            if (cur_state.depth >= LIMIT) begin
               st.err = ST_DEEP;
            end else begin
               st.depth = cur_state.depth + 8'd1;
               st.root  = 1'b1;
               st.mode  = MODE_NAME_START;
               ev       = EV_OPEN;
            end
         end else if (byte_in == CH_QUOTE) begin
            st.root = 1'b1;
            st.mode = MODE_STR;
            ev      = EV_STR_OPEN;
         end else if (is_tok(byte_in)) begin
            st.root = 1'b1;
            st.mode = MODE_TOKEN;
            ev      = EV_TOKEN;
            ch      = byte_in;
            first   = 1'b1;
         end else begin
            st.err = ST_BAD_CHAR;
         end
      end

      if (!is_last) begin
         status = ST_OK;
      end else if (st.err != ST_OK) begin
         status = st.err;
      end else if (st.mode == MODE_STR || st.mode == MODE_ESC) begin
         status = ST_OPEN_STR;
      end else if (st.mode == MODE_NAME_START) begin
         status = ST_BAD_CHAR;
      end else if (st.depth != 8'd0) begin
         status = ST_NO_CLOSE;
      end else if (!st.root) begin
         status = ST_NO_NODE;
      end else begin
         status = ST_OK;
      end

      result.event_kind = ev;
      result.char_value = ch;
      result.first_char = first;
      result.nest_depth = st.depth;
      result.doc_done   = is_last;
      result.doc_status = status;

      // The last byte closes the document; the next byte starts afresh.
      if (is_last) begin
         nxt_state = '{mode: MODE_GAP, depth: 8'd0, err: ST_OK, root: 1'b0};
      end else begin
         nxt_state = st;
      end
   end

endmodule

>>> design/sexpr_stream_lexer_core.sv
// ----------------------------------------------------------------------------
// sexpr_stream_lexer_core
// Streaming S-expression lexer: one classified event per document byte.
// ----------------------------------------------------------------------------
// The req channel carries one document byte per transaction together with an
// is_last flag that marks the final byte of a document. The rsp channel
// returns exactly one result transaction per byte: the event kind, the
// resolved character, a first-character flag, the nesting depth after the
// byte and, on the last byte, the document status.
// A byte accepted at a clock edge is offered on rsp right after that edge,
// unless an untaken result holds the output. Throughput is one byte per
// cycle while rsp keeps up, set by the single lexer state register per byte.
// The result register is backed by a one-entry skid register, so a byte is
// still accepted while a result waits; req.ready drops only when both hold
// results, and rises again as soon as rsp takes one.
// Reset clears the lexer state to top level before the root, with depth zero
// and no error, and empties both result registers. After the result for a
// byte flagged last, the lexer state returns to that same reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sexpr_stream_lexer_core_defines.svh"

module sexpr_stream_lexer_core #(
   parameter int MAX_DEPTH = sxl_pkg::MAX_DEPTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   sxl_req_if.sink  req_chan,
   sxl_rsp_if.source rsp_chan
);
   import sxl_pkg::*;

   localparam int DEPTH_LIMIT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

   state_type  state_ff, state_in;
   result_type step_result;

   result_type out_data_ff, out_data_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       skid_valid_ff, skid_valid_in;

   logic accept;
   logic out_fire;

   // The whole lexing step for one byte is combinational from the current
   // state and the incoming byte.
   sxl_step #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_step (
      .byte_in   (req_chan.byte_in),
      .is_last   (req_chan.is_last),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   // A new byte is taken whenever the skid register is free.
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_fire       = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;

      if (out_fire) begin
         out_valid_in = 1'b0;
      end

      if (skid_valid_ff) begin
         // No byte is accepted here, so only the skid entry can move up.
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_data_in  = step_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = step_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{mode: MODE_GAP, depth: 8'd0, err: ST_OK, root: 1'b0};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_kind = out_data_ff.event_kind;
   assign rsp_chan.char_value = out_data_ff.char_value;
   assign rsp_chan.first_char = out_data_ff.first_char;
   assign rsp_chan.nest_depth = out_data_ff.nest_depth;
   assign rsp_chan.doc_done   = out_data_ff.doc_done;
   assign rsp_chan.doc_status = out_data_ff.doc_status;

   // The skid entry is only ever filled behind a held result.
   `SXL_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid holds data while output is empty")

   // The nesting depth never passes the configured limit.
   `SXL_ASSERT_ALWAYS(a_depth_limit, state_ff.depth <= 8'(DEPTH_LIMIT), "nesting depth above limit")

   // The last byte of a document returns the lexer to its reset state.
   `SXL_ASSERT_NEXT(a_doc_restart, accept && req_chan.is_last, state_ff.depth == 8'd0 && state_ff.mode == MODE_GAP && state_ff.err == ST_OK && !state_ff.root, "state not cleared after last byte")

   // An error stays put until the document ends.
   `SXL_ASSERT_NEXT(a_error_sticky, state_ff.err != ST_OK && !(accept && req_chan.is_last), $stable(state_ff), "lexer state moved after an error")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming S-expression lexer core. Documents are
// queued up front: a handful of hand-written ones, then generated documents
// that are mostly well-formed with random content, plus corrupted, truncated,
// extra-root and noise documents. Every accepted byte is run through a local
// lexer model and the result transactions are compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import sxl_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RANDOM_BYTES  = 1200;
   localparam int TAIL_CYCLES   = 8;
   localparam int DUT_MAX_DEPTH = MAX_DEPTH_DEFAULT;
   // The depth register is 8 bits wide, so the usable limit saturates at 255.
   localparam int DEPTH_CAP     = (DUT_MAX_DEPTH < 255) ? DUT_MAX_DEPTH : 255;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } doc_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sxl_req_if byte_chan ();
   sxl_rsp_if event_chan ();

   sexpr_stream_lexer_core #(
      .MAX_DEPTH (DUT_MAX_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (byte_chan),
      .rsp_chan (event_chan)
   );

   always #(CLK_HALF) clock = ~clock;

   // Bytes waiting to be sent, the document under construction, and the
   // results the lexer model predicts for bytes already accepted.
   doc_byte_type pending_bytes[$];
   logic [7:0]   doc_bytes[$];
   result_type   expected_events[$];

   int sent_count  = 0;
   int total_items = 0;
   int fail_count  = 0;

   // -------------------------------------------------------------------------
   // Lexer model state. It mirrors the state of the block: the lexer mode,
   // the list depth, the first error seen in this document, and whether a
   // root node has begun.
   // -------------------------------------------------------------------------
   mode_type   lx_mode  = MODE_GAP;
   int         lx_depth = 0;
   status_type lx_err   = ST_OK;
   logic       lx_root  = 1'b0;

   // Event of the byte being modeled.
   event_type  cur_kind;
   logic [7:0] cur_char;
   logic       cur_first;

   function automatic logic white_byte(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h0C) || (b == 8'h0D) || (b == 8'h09) ||
             (b == 8'h0B);
   endfunction

   // Characters that may form a list name or a bare token.
   function automatic logic name_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == CH_BSLASH || b == CH_DOT ||
             b == CH_COLON || b == CH_USCORE || b == CH_DASH;
   endfunction

   // Resolves the byte after a backslash in a string. Returns 0 when the
   // escape is not one of the eleven accepted codes.
   function automatic logic resolve_escape(input logic [7:0] b,
                                           output logic [7:0] v);
      v = b;
      case (b)
         "'", "\"", "?", "\\": return 1'b1;
         "a": v = 8'h07;
         "b": v = 8'h08;
         "f": v = 8'h0C;
         "n": v = 8'h0A;
         "r": v = 8'h0D;
         "t": v = 8'h09;
         "v": v = 8'h0B;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic note_event(input event_type k, input logic [7:0] c,
                             input logic f);
      cur_kind  = k;
      cur_char  = c;
      cur_first = f;
   endtask

   // A byte seen between items, or one that ends a name or a token.
   task automatic lex_between(input logic [7:0] b);
      lx_mode = MODE_GAP;
      if (white_byte(b)) return;
      if (b == CH_SEMI) begin
         lx_mode = MODE_COMMENT;
         return;
      end
      if (lx_depth == 0) begin
         // Top level: newlines vanish, and nothing else may follow the root.
         if (b == CH_NL) return;
         if (lx_root) begin
            lx_err = ST_EXTRA;
            return;
         end
      end else if (b == CH_NL) begin
         note_event(EV_BREAK, 8'h00, 1'b0);
         return;
      end else if (b == CH_RPAREN) begin
         lx_depth--;
         note_event(EV_CLOSE, 8'h00, 1'b0);
         return;
      end
      if (b == CH_LPAREN) begin
         if (lx_depth >= DEPTH_CAP) begin
            lx_err = ST_DEEP;
            return;
         end
         lx_depth++;
         lx_root = 1'b1;
         lx_mode = MODE_NAME_START;
         note_event(EV_OPEN, 8'h00, 1'b0);
         return;
      end
      if (b == CH_QUOTE) begin
         lx_root = 1'b1;
         lx_mode = MODE_STR;
         note_event(EV_STR_OPEN, 8'h00, 1'b0);
         return;
      end
      if (name_byte(b)) begin
         lx_root = 1'b1;
         lx_mode = MODE_TOKEN;
         note_event(EV_TOKEN, b, 1'b1);
         return;
      end
      // A close before any root or a byte that cannot start an item.
      lx_err = ST_BAD_CHAR;
   endtask

   // Advances the model by one accepted byte and queues the result it owes.
   task automatic predict_lexer_event(input logic [7:0] b, input logic last);
      result_type r;
      logic [7:0] resolved;
      note_event(EV_SKIP, 8'h00, 1'b0);
      // After an error the state is frozen and every byte is skipped.
      if (lx_err == ST_OK) begin
         case (lx_mode)
            MODE_COMMENT: begin
               if (b == CH_NL) begin
                  lx_mode = MODE_GAP;
                  if (lx_depth != 0) note_event(EV_BREAK, 8'h00, 1'b0);
               end
            end
            MODE_NAME_START: begin
               if (name_byte(b)) begin
                  lx_mode = MODE_NAME;
                  note_event(EV_NAME, b, 1'b1);
               end else begin
                  lx_err = ST_BAD_CHAR;
               end
            end
            MODE_NAME: begin
               if (name_byte(b)) note_event(EV_NAME, b, 1'b0);
               else lex_between(b);
            end
            MODE_TOKEN: begin
               if (name_byte(b)) note_event(EV_TOKEN, b, 1'b0);
               else lex_between(b);
            end
            MODE_STR: begin
               if (b == CH_QUOTE) begin
                  lx_mode = MODE_GAP;
                  note_event(EV_STR_CLOSE, 8'h00, 1'b0);
               end else if (b == CH_BSLASH) begin
                  // The backslash itself is skipped.
                  lx_mode = MODE_ESC;
               end else begin
                  note_event(EV_STR_CHAR, b, 1'b0);
               end
            end
            MODE_ESC: begin
               if (resolve_escape(b, resolved)) begin
                  lx_mode = MODE_STR;
                  note_event(EV_STR_CHAR, resolved, 1'b0);
               end else begin
                  lx_err = ST_BAD_ESC;
               end
            end
            default: lex_between(b);
         endcase
      end

      r.event_kind = cur_kind;
      r.char_value = cur_char;
      r.first_char = cur_first;
      r.nest_depth = 8'(lx_depth);
      r.doc_done   = last;
      r.doc_status = ST_OK;
      if (last) begin
         if (lx_err != ST_OK) r.doc_status = lx_err;
         else if (lx_mode == MODE_STR || lx_mode == MODE_ESC) r.doc_status = ST_OPEN_STR;
         else if (lx_mode == MODE_NAME_START) r.doc_status = ST_BAD_CHAR;
         else if (lx_depth != 0) r.doc_status = ST_NO_CLOSE;
         else if (!lx_root) r.doc_status = ST_NO_NODE;
         // The end of a document returns everything to the reset state.
         lx_mode  = MODE_GAP;
         lx_depth = 0;
         lx_err   = ST_OK;
         lx_root  = 1'b0;
      end
      expected_events.push_back(r);
   endtask

   // -------------------------------------------------------------------------
   // Document generation. Bytes collect in doc_bytes and are moved to the
   // send queue as one document, with the last flag on its final byte.
   // -------------------------------------------------------------------------
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endtask

   task automatic flush_doc();
      doc_byte_type d;
      for (int i = 0; i < doc_bytes.size(); i++) begin
         d.value = doc_bytes[i];
         d.last  = (i == doc_bytes.size() - 1);
         pending_bytes.push_back(d);
      end
      doc_bytes.delete();
   endtask

   function automatic logic [7:0] random_name_char();
      int r;
      r = $urandom_range(0, 66);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      case (r)
         62: return CH_BSLASH;
         63: return CH_DOT;
         64: return CH_COLON;
         65: return CH_USCORE;
         default: return CH_DASH;
      endcase
   endfunction

   function automatic logic [7:0] random_white_char();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return 8'h0C;
         2: return 8'h0D;
         3: return 8'h09;
         default: return 8'h0B;
      endcase
   endfunction

   function automatic logic [7:0] random_escape_code();
      case ($urandom_range(0, 10))
         0: return "'";
         1: return "\"";
         2: return "?";
         3: return "\\";
         4: return "a";
         5: return "b";
         6: return "f";
         7: return "n";
         8: return "r";
         9: return "t";
         default: return "v";
      endcase
   endfunction

   // One separator: whitespace, a newline, or a comment up to its newline.
   task automatic add_separator();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0, 1: doc_bytes.push_back(random_white_char());
         2: doc_bytes.push_back(CH_NL);
         default: begin
            doc_bytes.push_back(CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
               c = 8'($urandom_range(0, 255));
               doc_bytes.push_back((c == CH_NL) ? 8'h20 : c);
            end
            doc_bytes.push_back(CH_NL);
         end
      endcase
   endtask

   task automatic add_gap();
      repeat ($urandom_range(0, 2)) add_separator();
   endtask

   // A random node: a list with a name and children, a token, or a string.
   task automatic add_node(input int level);
      int         pick;
      logic [7:0] c;
      pick = $urandom_range(0, 2);
      if (level >= 4 && pick == 0) pick = 1;
      case (pick)
         0: begin
            doc_bytes.push_back(CH_LPAREN);
            repeat ($urandom_range(1, 4)) doc_bytes.push_back(random_name_char());
            repeat ($urandom_range(0, 3)) begin
               add_separator();
               add_node(level + 1);
            end
            add_gap();
            doc_bytes.push_back(CH_RPAREN);
         end
         1: begin
            repeat ($urandom_range(1, 5)) doc_bytes.push_back(random_name_char());
         end
         default: begin
            doc_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 3) == 0) begin
                  doc_bytes.push_back(CH_BSLASH);
                  doc_bytes.push_back(random_escape_code());
               end else begin
                  // Any byte, non-ASCII included, except the two that
                  // would end the string or start an escape.
                  c = 8'($urandom_range(0, 255));
                  if (c == CH_QUOTE || c == CH_BSLASH) c = "z";
                  doc_bytes.push_back(c);
               end
            end
            doc_bytes.push_back(CH_QUOTE);
         end
      endcase
   endtask

   task automatic add_clean_doc();
      add_gap();
      add_node(0);
      add_gap();
   endtask

   // Most documents are well formed so that the deeper lexer modes are
   // reached; the rest are damaged in one of several ways, or plain noise.
   task automatic add_random_doc();
      int pick;
      int keep;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         add_clean_doc();
      end else if (pick < 78) begin
         add_clean_doc();
         doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 86) begin
         add_clean_doc();
         keep = $urandom_range(1, doc_bytes.size());
         while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
      end else if (pick < 93) begin
         add_clean_doc();
         add_separator();
         add_node(3);
      end else begin
         repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'($urandom_range(0, 255)));
      end
      flush_doc();
   endtask

   // -------------------------------------------------------------------------
   // Idling. The run falls into thirds by the number of bytes sent: first the
   // sender idles rarely and the receiver often, then the other way round,
   // and in the last third neither side idles.
   // -------------------------------------------------------------------------
   function automatic int idle_phase();
      if (total_items == 0) return 0;
      return (sent_count * 3) / total_items;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_phase())
         0: return 13;
         1: return 83;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_phase())
         0: return 83;
         1: return 13;
         default: return 0;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Driver. Each byte accepted at this edge goes through the model first;
   // then the next byte is offered unless the sender idles. A byte stays on
   // the channel untouched until its transaction completes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      doc_byte_type nxt;
      if (reset) begin
         byte_chan.valid   <= 1'b0;
         byte_chan.byte_in <= 8'h00;
         byte_chan.is_last <= 1'b0;
      end else begin
         if (byte_chan.valid && byte_chan.ready) begin
            predict_lexer_event(byte_chan.byte_in, byte_chan.is_last);
            sent_count++;
         end
         if (!byte_chan.valid || byte_chan.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               nxt = pending_bytes.pop_front();
               byte_chan.valid   <= 1'b1;
               byte_chan.byte_in <= nxt.value;
               byte_chan.is_last <= nxt.last;
            end else begin
               byte_chan.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. Each result transaction is matched against the oldest
   // prediction, every field on its own; ready is then redrawn.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         event_chan.ready <= 1'b0;
      end else begin
         if (event_chan.valid && event_chan.ready) begin
            if (expected_events.size() == 0) begin
               $error("result transaction with no byte awaiting one");
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (event_chan.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d",
                         want.event_kind, event_chan.event_kind);
                  fail_count++;
               end
               if (event_chan.char_value !== want.char_value) begin
                  $error("char_value: expected 0x%02h, actual 0x%02h",
                         want.char_value, event_chan.char_value);
                  fail_count++;
               end
               if (event_chan.first_char !== want.first_char) begin
                  $error("first_char: expected %0d, actual %0d",
                         want.first_char, event_chan.first_char);
                  fail_count++;
               end
               if (event_chan.nest_depth !== want.nest_depth) begin
                  $error("nest_depth: expected %0d, actual %0d",
                         want.nest_depth, event_chan.nest_depth);
                  fail_count++;
               end
               if (event_chan.doc_done !== want.doc_done) begin
                  $error("doc_done: expected %0d, actual %0d",
                         want.doc_done, event_chan.doc_done);
                  fail_count++;
               end
               if (event_chan.doc_status !== want.doc_status) begin
                  $error("doc_status: expected %0d, actual %0d",
                         want.doc_status, event_chan.doc_status);
                  fail_count++;
               end
            end
         end
         event_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin
      int directed_count;

      // Channel inputs are known before the first edge.
      byte_chan.valid   = 1'b0;
      byte_chan.byte_in = 8'h00;
      byte_chan.is_last = 1'b0;
      event_chan.ready  = 1'b0;

      // Directed documents. Each one ends on its own last byte.
      add_text("(");             // document ends right after an open
      flush_doc();
      add_text(")");             // close before any root
      flush_doc();
      add_text("\n");            // top-level newline only, no node
      flush_doc();
      // Open, name, comment ending in a line break, token, string with an
      // escape and a non-ASCII byte, string close and list close.
      add_text("(a;\nt \"\\n");
      doc_bytes.push_back(8'hFF);
      add_text("\")");
      flush_doc();
      add_text("x y");           // a second root after the first
      flush_doc();
      add_text("\"\\q\"");       // unknown escape; the rest is skipped
      flush_doc();
      add_text("\"a");           // string left open
      flush_doc();
      add_text("(a");            // list left open
      flush_doc();
      doc_bytes.push_back(8'h00);  // a byte that starts no item
      flush_doc();
      directed_count = pending_bytes.size();

      // One document that nests to the full depth and then asks for one
      // more level, which must be refused as too deep.
      repeat (DEPTH_CAP + 1) add_text("(a");
      flush_doc();

      while (pending_bytes.size() < directed_count + RANDOM_BYTES) add_random_doc();
      total_items = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every result to come back.
      while (pending_bytes.size() != 0 || byte_chan.valid || expected_events.size() != 0)
         @(posedge clock);
      // A tail wait follows so that a spurious late result is caught too.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_events.size() != 0) begin
         $error("%0d predicted results never arrived", expected_events.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(2_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
